// ----- hdl/tdfa_pkg.sv -----
// tdfa_pkg: shared codes and field widths for the table-driven dfa recognizer
package tdfa_pkg;

  // field widths
  localparam int LABEL_W  = 8;
  localparam int COUNT_W  = 5;
  localparam int REQ_W    = 3;
  localparam int IDX_W    = 4;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LABEL  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_SYMBOL = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TRANS  = 3'd2;
  localparam logic [REQ_W-1:0] REQ_CHAR   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FINISH = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_SYMBOL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_STATE   = 2'd2;

  // result kinds
  localparam logic KIND_TRACE   = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // register indexes
  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_ACCEPT = 2'd1;
  localparam logic [1:0] REG_SCOUNT = 2'd2;
  localparam logic [1:0] REG_YCOUNT = 2'd3;

endpackage

// ----- hdl/table_driven_dfa_recognizer.sv -----
// table_driven_dfa_recognizer: programmable byte-labelled dfa, one item per cycle unless stalled
//
// Input channel (in_valid / in_stall) carries req_type, row_index, col_index and
// item_value. Items load the state label, symbol and next-state tables, feed a
// character, or finish a string. Output channel (out_valid / out_stall) carries
// one result for each character (trace, unless the string already faulted) and
// for each finish (verdict). Table loads and unused codes give no result.
// Configuration registers (start, accept label, state and symbol counts) sit on
// the APB port at byte addresses 0, 4, 8, 12; write them only while idle.
// An item is taken into the input register, then searched and moved into the
// output register once the output is free to advance. Throughput: one item per
// cycle while the receiver does not stall. The next-state table is a memory
// whose registered read data feeds the next character's label search directly,
// which closes the loop from one character to the next.
// Reset clears the valid flags, the string state and the registers; the tables
// are undefined until loaded. When the receiver stalls, the output holds and
// the input stalls once the input register is also full.
module table_driven_dfa_recognizer #(
  parameter int STATE_ENTRIES = 16,
  parameter int NUM_SYMBOLS   = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tdfa_pkg::REQ_W-1:0]      req_type,
  input  logic [tdfa_pkg::IDX_W-1:0]      row_index,
  input  logic [tdfa_pkg::IDX_W-1:0]      col_index,
  input  logic [tdfa_pkg::LABEL_W-1:0]    item_value,
  // output channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            result_kind,
  output logic [tdfa_pkg::LABEL_W-1:0]    shown_label,
  output logic                            accepted,
  output logic [tdfa_pkg::STATUS_W-1:0]   status,
  // configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tdfa_pkg::ADDR_W-1:0]     paddr,
  input  logic [tdfa_pkg::DATA_W-1:0]     pwdata,
  output logic [tdfa_pkg::DATA_W-1:0]     prdata,
  output logic                            pready
);
  import tdfa_pkg::*;

  localparam int RW    = (STATE_ENTRIES > 1) ? $clog2(STATE_ENTRIES) : 1;
  localparam int CW    = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int DEPTH = STATE_ENTRIES * NUM_SYMBOLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // configuration registers
  logic [LABEL_W-1:0] start_label;
  logic [LABEL_W-1:0] accept_label;
  logic [COUNT_W-1:0] state_count;
  logic [COUNT_W-1:0] symbol_count;

  // input register
  logic               s1_valid;
  logic [REQ_W-1:0]   s1_req;
  logic [IDX_W-1:0]   s1_row;
  logic [IDX_W-1:0]   s1_col;
  logic [LABEL_W-1:0] s1_val;

  // tables and string state
  logic [LABEL_W-1:0]  label_table [STATE_ENTRIES];
  logic [LABEL_W-1:0]  symbol_table [NUM_SYMBOLS];
  logic [LABEL_W-1:0]  next_table [DEPTH];
  logic [LABEL_W-1:0]  mem_q;
  logic [LABEL_W-1:0]  cur_hold;
  logic                use_mem;
  logic                in_string;
  logic [STATUS_W-1:0] fault_code;

  // datapath signals
  logic                advance;
  logic                fire;
  logic [LABEL_W-1:0]  cur_now;
  logic [LABEL_W-1:0]  eff_cur;
  logic [STATUS_W-1:0] eff_fault;
  logic                r_hit;
  logic [RW-1:0]       r_idx;
  logic                c_hit;
  logic [CW-1:0]       c_idx;
  logic [STATUS_W-1:0] char_st;
  logic [8:0]          row_w;
  logic [8:0]          col_w;
  logic                row_ok;
  logic                col_ok;
  logic [16:0]         rd_addr_w;
  logic [16:0]         wr_addr_w;
  logic                produce;
  logic                char_move;

  assign pready = 1'b1;

  // handshake
  assign advance  = !out_valid || !out_stall;
  assign fire     = s1_valid && advance;
  assign in_stall = s1_valid && !advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_label  <= '0;
      accept_label <= '0;
      state_count  <= COUNT_W'(1);
      symbol_count <= COUNT_W'(1);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_START:  start_label  <= pwdata[LABEL_W-1:0];
        REG_ACCEPT: accept_label <= pwdata[LABEL_W-1:0];
        REG_SCOUNT: state_count  <= pwdata[COUNT_W-1:0];
        REG_YCOUNT: symbol_count <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // configuration reads
  always_comb begin
    unique case (paddr[3:2])
      REG_START:  prdata = {{(DATA_W-LABEL_W){1'b0}}, start_label};
      REG_ACCEPT: prdata = {{(DATA_W-LABEL_W){1'b0}}, accept_label};
      REG_SCOUNT: prdata = {{(DATA_W-COUNT_W){1'b0}}, state_count};
      REG_YCOUNT: prdata = {{(DATA_W-COUNT_W){1'b0}}, symbol_count};
      default:    prdata = '0;
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_req <= req_type;
      s1_row <= row_index;
      s1_col <= col_index;
      s1_val <= item_value;
    end
  end

  // current label and string opening
  assign cur_now   = use_mem ? mem_q : cur_hold;
  assign eff_cur   = in_string ? cur_now : start_label;
  assign eff_fault = in_string ? fault_code : ST_OK;

  // first matching state label
  always_comb begin
    r_hit = 1'b0;
    r_idx = '0;
    for (int i = STATE_ENTRIES - 1; i >= 0; i--) begin
      if (i < int'(state_count) && label_table[i] == eff_cur) begin
        r_hit = 1'b1;
        r_idx = RW'(i);
      end
    end
  end

  // first matching symbol
  always_comb begin
    c_hit = 1'b0;
    c_idx = '0;
    for (int i = NUM_SYMBOLS - 1; i >= 0; i--) begin
      if (i < int'(symbol_count) && symbol_table[i] == s1_val) begin
        c_hit = 1'b1;
        c_idx = CW'(i);
      end
    end
  end

  // trace status, unknown symbol first
  always_comb begin
    priority if (!c_hit) begin
      char_st = ST_BAD_SYMBOL;
    end else if (!r_hit) begin
      char_st = ST_NO_STATE;
    end else begin
      char_st = ST_OK;
    end
  end

  // index checks and table addresses
  assign row_w     = {5'b0, s1_row};
  assign col_w     = {5'b0, s1_col};
  assign row_ok    = int'(row_w) < STATE_ENTRIES;
  assign col_ok    = int'(col_w) < NUM_SYMBOLS;
  assign rd_addr_w = 17'(r_idx) * 17'(NUM_SYMBOLS) + 17'(c_idx);
  assign wr_addr_w = 17'(row_w) * 17'(NUM_SYMBOLS) + 17'(col_w);

  assign char_move = fire && s1_req == REQ_CHAR && eff_fault == ST_OK && char_st == ST_OK;
  assign produce   = (s1_req == REQ_CHAR && eff_fault == ST_OK) || s1_req == REQ_FINISH;

  // small tables
  always_ff @(posedge clk) begin
    if (fire && s1_req == REQ_LABEL && row_ok) begin
      label_table[row_w[RW-1:0]] <= s1_val;
    end
    if (fire && s1_req == REQ_SYMBOL && col_ok) begin
      symbol_table[col_w[CW-1:0]] <= s1_val;
    end
  end

  // next-state memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (fire && s1_req == REQ_TRANS && row_ok && col_ok) begin
      next_table[wr_addr_w[AW-1:0]] <= s1_val;
    end
    if (char_move) begin
      mem_q <= next_table[rd_addr_w[AW-1:0]];
    end
  end

  // string state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_string  <= 1'b0;
      fault_code <= ST_OK;
      use_mem    <= 1'b0;
      cur_hold   <= '0;
    end else if (fire) begin
      if ((s1_req == REQ_CHAR || s1_req == REQ_FINISH) && !in_string) begin
        cur_hold <= start_label;
        use_mem  <= 1'b0;
      end
      if (s1_req == REQ_CHAR) begin
        in_string <= 1'b1;
        if (!in_string) begin
          fault_code <= ST_OK;
        end
        if (eff_fault == ST_OK) begin
          if (char_st == ST_OK) begin
            use_mem <= 1'b1;
          end else begin
            fault_code <= char_st;
          end
        end
      end else if (s1_req == REQ_FINISH) begin
        in_string  <= 1'b0;
        fault_code <= ST_OK;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && produce) begin
      shown_label <= eff_cur;
      if (s1_req == REQ_FINISH) begin
        result_kind <= KIND_VERDICT;
        accepted    <= (eff_fault == ST_OK) && (eff_cur == accept_label);
        status      <= eff_fault;
      end else begin
        result_kind <= KIND_TRACE;
        accepted    <= 1'b0;
        status      <= char_st;
      end
    end
  end

endmodule

// ----- hdl/tdfa_checker.sv -----
// tdfa_checker: port-level checks for the dfa recognizer, bound to the top level
module tdfa_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          result_kind,
  input logic [tdfa_pkg::LABEL_W-1:0]  shown_label,
  input logic                          accepted,
  input logic [tdfa_pkg::STATUS_W-1:0] status
);
  import tdfa_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(shown_label) && $stable(status)
      && $stable(result_kind) && $stable(accepted))
    else $error("stalled result changed");

  // a trace never claims acceptance
  a_trace_acc: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == KIND_TRACE |-> !accepted)
    else $error("trace item marked accepted");

  // acceptance only without a fault
  a_acc_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> status == ST_OK)
    else $error("accepted with fault status");

  // reset empties the output
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind table_driven_dfa_recognizer tdfa_checker u_tdfa_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .result_kind (result_kind),
  .shown_label (shown_label),
  .accepted    (accepted),
  .status      (status)
);
